>>> rtl/char_lcd_4bit_write_sequencer_top_macros.svh
// Assertion helpers for the sequencer core RTL.
`ifndef CHAR_LCD_4BIT_WRITE_SEQUENCER_TOP_MACROS_SVH
`define CHAR_LCD_4BIT_WRITE_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication, checks off during reset.
`define CLCD_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("clcd assertion failed");

// Next-cycle implication, checks off during reset.
`define CLCD_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("clcd assertion failed");

`endif

>>> rtl/clcd_pkg.sv
`timescale 1ns / 1ps

package clcd_pkg;

   localparam int COUNTER_WIDTH = 16;
   localparam int WAIT_WIDTH    = 16;
   localparam int PULSE_WIDTH   = 8;
   localparam int CSR_IDX_WIDTH = 3;

   localparam logic [COUNTER_WIDTH-1:0] COUNT_MAX = {COUNTER_WIDTH{1'b1}};

   localparam logic [3:0] INIT_ITEMS = 4'd8;

   // request codes; code 3 behaves as a tick
   localparam logic [1:0] REQ_TICK = 2'd0;
   localparam logic [1:0] REQ_CMD  = 2'd1;
   localparam logic [1:0] REQ_DATA = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_POWERUP_WAIT  = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SECOND_INIT   = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_THIRD_INIT    = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SHORT_SETTLE  = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_LONG_SETTLE   = 3'd4;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_ENABLE_PULSE  = 3'd5;

   // register reset values
   localparam logic [WAIT_WIDTH-1:0]  RST_POWERUP_WAIT = 16'd20000;
   localparam logic [WAIT_WIDTH-1:0]  RST_SECOND_INIT  = 16'd5000;
   localparam logic [WAIT_WIDTH-1:0]  RST_THIRD_INIT   = 16'd100;
   localparam logic [WAIT_WIDTH-1:0]  RST_SHORT_SETTLE = 16'd40;
   localparam logic [WAIT_WIDTH-1:0]  RST_LONG_SETTLE  = 16'd1640;
   localparam logic [PULSE_WIDTH-1:0] RST_ENABLE_PULSE = 8'd1;

   // clear and home commands sit below this value
   localparam logic [7:0] LONG_CMD_LIMIT = 8'h04;

   typedef enum logic [2:0] {
      PH_PWR,
      PH_SETUP,
      PH_PULSE,
      PH_SETTLE,
      PH_IDLE
   } phase_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] byte_value;
   } clcd_req_type;

   typedef struct packed {
      logic [3:0] bus_nibble;
      logic       select_line;
      logic       rw_line;
      logic       enable_line;
      logic       ready_res;
      logic       rejected;
   } clcd_rsp_type;

   typedef struct packed {
      logic [WAIT_WIDTH-1:0]  powerup_wait;
      logic [WAIT_WIDTH-1:0]  second_init_wait;
      logic [WAIT_WIDTH-1:0]  third_init_wait;
      logic [WAIT_WIDTH-1:0]  short_settle_wait;
      logic [WAIT_WIDTH-1:0]  long_settle_wait;
      logic [PULSE_WIDTH-1:0] enable_pulse_len;
   } clcd_cfg_type;

   function automatic logic [7:0] init_byte(input logic [2:0] k);
      logic [7:0] b;
      unique case (k)
         3'd0, 3'd1, 3'd2: b = 8'h30;
         3'd3:             b = 8'h20;
         3'd4:             b = 8'h28;
         3'd5:             b = 8'h06;
         3'd6:             b = 8'h01;
         default:          b = 8'h0F;
      endcase
      return b;
   endfunction

endpackage

>>> rtl/char_lcd_4bit_write_sequencer_top.sv
`timescale 1ns / 1ps

// 4-bit character LCD write sequencer. Each request is a 1 us tick, a command
// byte or a data byte; each one gives exactly one response carrying the pin
// levels after it, ready_res, and rejected for a byte that came while busy.
// After reset the power-up wait and the init sequence run on ticks alone. The
// block takes one request per cycle: a request is worked out in one pass of
// logic from the state registers and its response lands in the output register
// the next cycle; req_ready only drops while that register is full and the
// consumer is stalling. The user writes wait and pulse registers via the csr
// port while no transfer is in flight, unchecked; indexes above 5 are ignored.
module char_lcd_4bit_write_sequencer_top (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  clcd_pkg::clcd_req_type  req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output clcd_pkg::clcd_rsp_type  rsp_data,
   input  logic                    csr_write_en,
   input  logic [2:0]              csr_index,
   input  logic [15:0]             csr_wdata
);
   import clcd_pkg::*;

   clcd_cfg_type cfg_ff, cfg_in;
   clcd_rsp_type rsp_data_ff;
   clcd_rsp_type core_result;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         advance;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign advance   = req_valid && req_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_POWERUP_WAIT: cfg_in.powerup_wait      = csr_wdata;
            CSR_SECOND_INIT:  cfg_in.second_init_wait  = csr_wdata;
            CSR_THIRD_INIT:   cfg_in.third_init_wait   = csr_wdata;
            CSR_SHORT_SETTLE: cfg_in.short_settle_wait = csr_wdata;
            CSR_LONG_SETTLE:  cfg_in.long_settle_wait  = csr_wdata;
            CSR_ENABLE_PULSE: cfg_in.enable_pulse_len  = csr_wdata[PULSE_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.powerup_wait      <= RST_POWERUP_WAIT;
         cfg_ff.second_init_wait  <= RST_SECOND_INIT;
         cfg_ff.third_init_wait   <= RST_THIRD_INIT;
         cfg_ff.short_settle_wait <= RST_SHORT_SETTLE;
         cfg_ff.long_settle_wait  <= RST_LONG_SETTLE;
         cfg_ff.enable_pulse_len  <= RST_ENABLE_PULSE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   clcd_seq_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (req_data),
      .cfg     (cfg_ff),
      .result  (core_result)
   );

   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= core_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> rtl/clcd_seq_core.sv
`timescale 1ns / 1ps
`include "char_lcd_4bit_write_sequencer_top_macros.svh"

module clcd_seq_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  clcd_pkg::clcd_req_type item,
   input  clcd_pkg::clcd_cfg_type cfg,
   output clcd_pkg::clcd_rsp_type result
);
   import clcd_pkg::*;

   phase_type                phase_ff, phase_in;
   logic [3:0]               init_step_ff, init_step_in;
   logic [COUNTER_WIDTH-1:0] wait_counter_ff, wait_counter_in;
   logic [7:0]               held_byte_ff, held_byte_in;
   logic                     lower_pending_ff, lower_pending_in;
   logic [3:0]               pin_nibble_ff, pin_nibble_in;
   logic                     pin_select_ff, pin_select_in;
   logic                     pin_enable_ff, pin_enable_in;

   logic                     rej;
   logic                     is_byte;
   logic [COUNTER_WIDTH-1:0] wc_sat;
   logic [WAIT_WIDTH-1:0]    settle_target;
   logic                     settle_done;
   logic                     pwr_done;
   logic                     pulse_done;
   logic [3:0]               step_next;
   logic                     start_item;
   logic [2:0]               start_k;
   logic [7:0]               start_byte;

   assign is_byte = (item.req_type == REQ_CMD) || (item.req_type == REQ_DATA);
   assign wc_sat  = (wait_counter_ff == COUNT_MAX) ? wait_counter_ff
                                                   : wait_counter_ff + 1'b1;

   always_comb begin
      priority if (init_step_ff == 4'd0) begin
         settle_target = cfg.second_init_wait;
      end else if (init_step_ff == 4'd1) begin
         settle_target = cfg.third_init_wait;
      end else if (!pin_select_ff && (held_byte_ff < LONG_CMD_LIMIT)) begin
         settle_target = cfg.long_settle_wait;
      end else begin
         settle_target = cfg.short_settle_wait;
      end
   end

   // saturated counter also ends any wait longer than the counter can hold
   assign pwr_done    = (wc_sat == COUNT_MAX) || (32'(wc_sat) >= 32'(cfg.powerup_wait));
   assign settle_done = (wc_sat == COUNT_MAX) || (32'(wc_sat) >= 32'(settle_target));
   assign pulse_done  = (wc_sat == COUNT_MAX) ||
                        (32'(wc_sat) >= 32'(cfg.enable_pulse_len));
   assign step_next   = init_step_ff + 4'd1;
   assign start_byte  = init_byte(start_k);

   // next state
   always_comb begin
      phase_in         = phase_ff;
      init_step_in     = init_step_ff;
      wait_counter_in  = wait_counter_ff;
      held_byte_in     = held_byte_ff;
      lower_pending_in = lower_pending_ff;
      pin_nibble_in    = pin_nibble_ff;
      pin_select_in    = pin_select_ff;
      pin_enable_in    = pin_enable_ff;
      rej              = 1'b0;
      start_item       = 1'b0;
      start_k          = 3'd0;

      if (advance) begin
         if (is_byte) begin
            if (phase_ff == PH_IDLE) begin
               held_byte_in     = item.byte_value;
               pin_select_in    = (item.req_type == REQ_DATA);
               lower_pending_in = 1'b1;
               pin_nibble_in    = item.byte_value[7:4];
               pin_enable_in    = 1'b0;
               wait_counter_in  = '0;
               phase_in         = PH_SETUP;
            end else begin
               rej = 1'b1;
            end
         end else begin
            unique case (phase_ff)
               PH_PWR: begin
                  wait_counter_in = wc_sat;
                  if (pwr_done) begin
                     start_item = 1'b1;
                     start_k    = 3'd0;
                  end
               end
               PH_SETUP: begin
                  pin_enable_in   = 1'b1;
                  phase_in        = PH_PULSE;
                  wait_counter_in = '0;
               end
               PH_PULSE: begin
                  wait_counter_in = wc_sat;
                  if (pulse_done) begin
                     pin_enable_in   = 1'b0;
                     wait_counter_in = '0;
                     if (lower_pending_ff) begin
                        lower_pending_in = 1'b0;
                        pin_nibble_in    = held_byte_ff[3:0];
                        phase_in         = PH_SETUP;
                     end else begin
                        phase_in = PH_SETTLE;
                     end
                  end
               end
               PH_SETTLE: begin
                  wait_counter_in = wc_sat;
                  if (settle_done) begin
                     wait_counter_in = '0;
                     if (init_step_ff < INIT_ITEMS) begin
                        init_step_in = step_next;
                        if (step_next < INIT_ITEMS) begin
                           start_item = 1'b1;
                           start_k    = step_next[2:0];
                        end else begin
                           phase_in = PH_IDLE;
                        end
                     end else begin
                        phase_in = PH_IDLE;
                     end
                  end
               end
               default: ;
            endcase
         end
      end

      if (start_item) begin
         held_byte_in     = start_byte;
         lower_pending_in = start_k[2];
         pin_select_in    = 1'b0;
         pin_nibble_in    = start_byte[7:4];
         pin_enable_in    = 1'b0;
         phase_in         = PH_SETUP;
         wait_counter_in  = '0;
      end
   end

   // result shows the state after this item
   always_comb begin
      result.bus_nibble  = pin_nibble_in;
      result.select_line = pin_select_in;
      result.rw_line     = 1'b0;
      result.enable_line = pin_enable_in;
      result.ready_res   = (phase_in == PH_IDLE);
      result.rejected    = rej;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_PWR;
         init_step_ff     <= 4'd0;
         wait_counter_ff  <= '0;
         held_byte_ff     <= 8'd0;
         lower_pending_ff <= 1'b0;
         pin_nibble_ff    <= 4'd0;
         pin_select_ff    <= 1'b0;
         pin_enable_ff    <= 1'b0;
      end else begin
         phase_ff         <= phase_in;
         init_step_ff     <= init_step_in;
         wait_counter_ff  <= wait_counter_in;
         held_byte_ff     <= held_byte_in;
         lower_pending_ff <= lower_pending_in;
         pin_nibble_ff    <= pin_nibble_in;
         pin_select_ff    <= pin_select_in;
         pin_enable_ff    <= pin_enable_in;
      end
   end

   `CLCD_ASSERT_NXT(a_reject_holds_phase, clock, reset, advance && rej,
      (phase_ff == $past(phase_ff)) && (pin_nibble_ff == $past(pin_nibble_ff)))
   `CLCD_ASSERT_IMP(a_enable_only_in_pulse, clock, reset, pin_enable_ff,
      phase_ff == PH_PULSE)
   `CLCD_ASSERT_IMP(a_idle_after_init, clock, reset, phase_ff == PH_IDLE,
      init_step_ff == INIT_ITEMS)
   `CLCD_ASSERT_IMP(a_lower_half_in_flight, clock, reset, lower_pending_ff,
      (phase_ff == PH_SETUP) || (phase_ff == PH_PULSE))

endmodule

>>> verif/clcd_pin_checker.sv
`timescale 1ns / 1ps

module clcd_pin_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  clcd_pkg::clcd_req_type req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  clcd_pkg::clcd_rsp_type rsp_data,
   input  logic                   csr_write_en,
   input  logic [2:0]             csr_index,
   input  logic [15:0]            csr_wdata,
   output int                     fail_count,
   output int                     pending_count
);

   import clcd_pkg::*;

   clcd_cfg_type             cfg;
   phase_type                phase;
   logic [3:0]               boot_step;
   logic [COUNTER_WIDTH-1:0] wait_count;
   logic [7:0]               held_byte;
   logic                     lower_pending;
   logic [3:0]               pin_nib;
   logic                     pin_sel;
   logic                     pin_en;

   clcd_rsp_type expected_pins[$];
   clcd_rsp_type want;
   int           failures = 0;
   int           pending = 0;

   assign fail_count    = failures;
   assign pending_count = pending;

   function automatic logic [7:0] boot_byte(input logic [2:0] k);
      logic [7:0] b;
      case (k)
         3'd0, 3'd1, 3'd2: b = 8'h30;
         3'd3:             b = 8'h20;
         3'd4:             b = 8'h28;
         3'd5:             b = 8'h06;
         3'd6:             b = 8'h01;
         default:          b = 8'h0F;
      endcase
      return b;
   endfunction

   // saturating count, target clipped to the counter range
   function automatic logic tick_reaches(input logic [31:0] target);
      logic [31:0] limit;
      limit = 32'(COUNT_MAX);
      if (wait_count != COUNT_MAX)
         wait_count = wait_count + 1'b1;
      if (target > limit)
         target = limit;
      return 32'(wait_count) >= target;
   endfunction

   function automatic void start_boot_item(input logic [3:0] k);
      held_byte     = boot_byte(k[2:0]);
      lower_pending = (k >= 4'd4);
      pin_sel       = 1'b0;
      pin_nib       = held_byte[7:4];
      pin_en        = 1'b0;
      phase         = PH_SETUP;
      wait_count    = '0;
   endfunction

   function automatic logic [15:0] settle_target();
      logic [15:0] t;
      if (boot_step == 4'd0)
         t = cfg.second_init_wait;
      else if (boot_step == 4'd1)
         t = cfg.third_init_wait;
      else if (!pin_sel && held_byte < LONG_CMD_LIMIT)
         t = cfg.long_settle_wait;
      else
         t = cfg.short_settle_wait;
      return t;
   endfunction

   function automatic void advance_tick();
      case (phase)
         PH_PWR: begin
            if (tick_reaches(32'(cfg.powerup_wait)))
               start_boot_item(4'd0);
         end
         PH_SETUP: begin
            pin_en     = 1'b1;
            phase      = PH_PULSE;
            wait_count = '0;
         end
         PH_PULSE: begin
            if (tick_reaches(32'(cfg.enable_pulse_len))) begin
               pin_en     = 1'b0;
               wait_count = '0;
               if (lower_pending) begin
                  lower_pending = 1'b0;
                  pin_nib       = held_byte[3:0];
                  phase         = PH_SETUP;
               end else begin
                  phase = PH_SETTLE;
               end
            end
         end
         PH_SETTLE: begin
            if (tick_reaches(32'(settle_target()))) begin
               wait_count = '0;
               if (boot_step < INIT_ITEMS) begin
                  boot_step = boot_step + 1'b1;
                  if (boot_step < INIT_ITEMS)
                     start_boot_item(boot_step);
                  else
                     phase = PH_IDLE;
               end else begin
                  phase = PH_IDLE;
               end
            end
         end
         default: ;
      endcase
   endfunction

   function automatic clcd_rsp_type predict_pins(input clcd_req_type r);
      clcd_rsp_type o;
      logic         dropped;
      dropped = 1'b0;
      if (r.req_type == REQ_CMD || r.req_type == REQ_DATA) begin
         if (phase == PH_IDLE) begin
            held_byte     = r.byte_value;
            pin_sel       = (r.req_type == REQ_DATA);
            lower_pending = 1'b1;
            pin_nib       = r.byte_value[7:4];
            pin_en        = 1'b0;
            wait_count    = '0;
            phase         = PH_SETUP;
         end else begin
            dropped = 1'b1;
         end
      end else begin
         advance_tick();
      end
      o.bus_nibble  = pin_nib;
      o.select_line = pin_sel;
      o.rw_line     = 1'b0;
      o.enable_line = pin_en;
      o.ready_res   = (phase == PH_IDLE);
      o.rejected    = dropped;
      return o;
   endfunction

   task automatic reset_model();
      cfg.powerup_wait      = RST_POWERUP_WAIT;
      cfg.second_init_wait  = RST_SECOND_INIT;
      cfg.third_init_wait   = RST_THIRD_INIT;
      cfg.short_settle_wait = RST_SHORT_SETTLE;
      cfg.long_settle_wait  = RST_LONG_SETTLE;
      cfg.enable_pulse_len  = RST_ENABLE_PULSE;
      phase         = PH_PWR;
      boot_step     = '0;
      wait_count    = '0;
      held_byte     = '0;
      lower_pending = 1'b0;
      pin_nib       = '0;
      pin_sel       = 1'b0;
      pin_en        = 1'b0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         reset_model();
         expected_pins.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_pins.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("unexpected response transfer: %h", rsp_data);
            end else begin
               want = expected_pins.pop_front();
               if (rsp_data.bus_nibble !== want.bus_nibble ||
                   rsp_data.select_line !== want.select_line ||
                   rsp_data.rw_line !== want.rw_line ||
                   rsp_data.enable_line !== want.enable_line ||
                   rsp_data.ready_res !== want.ready_res ||
                   rsp_data.rejected !== want.rejected) begin
                  failures++;
                  if (failures <= 10) begin
                     $display("pin mismatch: expected nib=%h rs=%b rw=%b en=%b rdy=%b rej=%b",
                              want.bus_nibble, want.select_line, want.rw_line,
                              want.enable_line, want.ready_res, want.rejected);
                     $display("              got      nib=%h rs=%b rw=%b en=%b rdy=%b rej=%b",
                              rsp_data.bus_nibble, rsp_data.select_line, rsp_data.rw_line,
                              rsp_data.enable_line, rsp_data.ready_res, rsp_data.rejected);
                  end
               end
            end
         end
         if (req_valid && req_ready)
            expected_pins.push_back(predict_pins(req_data));
         if (csr_write_en) begin
            case (csr_index)
               CSR_POWERUP_WAIT: cfg.powerup_wait      = csr_wdata;
               CSR_SECOND_INIT:  cfg.second_init_wait  = csr_wdata;
               CSR_THIRD_INIT:   cfg.third_init_wait   = csr_wdata;
               CSR_SHORT_SETTLE: cfg.short_settle_wait = csr_wdata;
               CSR_LONG_SETTLE:  cfg.long_settle_wait  = csr_wdata;
               CSR_ENABLE_PULSE: cfg.enable_pulse_len  = csr_wdata[7:0];
               default: ;
            endcase
         end
      end
      pending = expected_pins.size();
   end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

   import clcd_pkg::*;

   localparam logic [1:0]               REQ_SPARE  = 2'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_FREE_6 = 3'd6;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_FREE_7 = 3'd7;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   clcd_req_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   clcd_rsp_type rsp_data;
   logic         csr_write_en;
   logic [2:0]   csr_index;
   logic [15:0]  csr_wdata;

   int fail_count;
   int pending_count;

   int req_taken = 0;
   int rsp_taken = 0;
   int burst_left = 0;
   int items_sent = 0;
   int bytes_offered = 0;
   int settings_used = 0;
   bit hold_request = 1'b0;

   clcd_cfg_type cur_cfg;

   char_lcd_4bit_write_sequencer_top dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   clcd_pin_checker pin_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   always @(posedge clock) begin
      if (req_valid && req_ready)
         req_taken <= req_taken + 1;
      if (rsp_valid && rsp_ready)
         rsp_taken <= rsp_taken + 1;
   end

   // receiver: random stall pattern, plus one long hold-off on request
   initial begin
      int run_left;
      int hold_left;
      bit stall_mode;
      run_left   = 0;
      hold_left  = 0;
      stall_mode = 1'b0;
      rsp_ready  = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (run_left == 0) begin
               run_left   = $urandom_range(5, 60);
               stall_mode = $urandom_range(0, 1);
            end
            run_left--;
            rsp_ready <= stall_mode ? ($urandom_range(0, 3) != 0) : 1'b1;
         end
      end
   end

   task automatic offer(input logic [1:0] kind, input logic [7:0] value);
      clcd_req_type item;
      item.req_type   = kind;
      item.byte_value = value;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      burst_left--;
      items_sent++;
      if (kind == REQ_CMD || kind == REQ_DATA)
         bytes_offered++;
   endtask

   function automatic logic [1:0] tick_code();
      return ($urandom_range(0, 7) == 0) ? REQ_SPARE : REQ_TICK;
   endfunction

   task automatic wait_all_done();
      @(posedge clock);
      while (rsp_taken != req_taken)
         @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      wait_all_done();
      burst_left = 0;
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
   endtask

   task automatic program_regs(input clcd_cfg_type c);
      logic [7:0] junk;
      junk = 8'($urandom);
      write_reg(CSR_POWERUP_WAIT, c.powerup_wait);
      write_reg(CSR_SECOND_INIT, c.second_init_wait);
      write_reg(CSR_THIRD_INIT, c.third_init_wait);
      write_reg(CSR_SHORT_SETTLE, c.short_settle_wait);
      write_reg(CSR_LONG_SETTLE, c.long_settle_wait);
      write_reg(CSR_ENABLE_PULSE, {junk, c.enable_pulse_len});
      write_reg($urandom_range(0, 1) ? CSR_FREE_6 : CSR_FREE_7, 16'($urandom));
      csr_write_en <= 1'b0;
      cur_cfg = c;
      settings_used++;
   endtask

   function automatic int byte_ticks(input logic [1:0] kind, input logic [7:0] value);
      int pulse;
      int settle;
      pulse = (cur_cfg.enable_pulse_len == 0) ? 1 : int'(cur_cfg.enable_pulse_len);
      if (kind == REQ_CMD && value < LONG_CMD_LIMIT)
         settle = int'(cur_cfg.long_settle_wait);
      else
         settle = int'(cur_cfg.short_settle_wait);
      if (settle == 0)
         settle = 1;
      return 2 + 2 * pulse + settle;
   endfunction

   task automatic byte_then_ticks(input logic [1:0] kind, input logic [7:0] value);
      offer(kind, value);
      repeat (byte_ticks(kind, value))
         offer(tick_code(), 8'($urandom));
   endtask

   // enough ticks to finish whatever byte is in flight
   task automatic quiesce();
      int n;
      n = byte_ticks(REQ_CMD, 8'h00);
      if (byte_ticks(REQ_DATA, 8'h00) > n)
         n = byte_ticks(REQ_DATA, 8'h00);
      repeat (n)
         offer(REQ_TICK, 8'($urandom));
   endtask

   task automatic random_sequence();
      logic [1:0] kind;
      logic [7:0] value;
      int         pick;
      int         n;
      pick  = $urandom_range(0, 9);
      kind  = $urandom_range(0, 1) ? REQ_DATA : REQ_CMD;
      value = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 7)) : 8'($urandom);
      if (pick < 8) begin
         offer(kind, value);
         n = byte_ticks(kind, value) + $urandom_range(0, 4) - 2;
         repeat (n)
            offer(tick_code(), 8'($urandom));
      end else if (pick == 8) begin
         offer(kind, value);
      end else begin
         repeat ($urandom_range(1, 4))
            offer(tick_code(), 8'($urandom));
      end
   endtask

   initial begin
      clcd_cfg_type c;
      req_valid    = 1'b0;
      req_data     = '0;
      csr_write_en = 1'b0;
      csr_index    = CSR_POWERUP_WAIT;
      csr_wdata    = '0;
      reset        = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // boot with short waits; bytes during init are dropped
      c = '0;
      c.powerup_wait     = 16'd2;
      c.enable_pulse_len = 8'd1;
      program_regs(c);
      repeat (8) offer(REQ_TICK, 8'($urandom));
      offer(REQ_CMD, 8'h01);
      offer(REQ_SPARE, 8'($urandom));
      offer(REQ_DATA, 8'hA5);
      repeat (45) offer(REQ_TICK, 8'($urandom));

      drain();
      c = '0;
      c.second_init_wait = 16'hFFFF;
      c.long_settle_wait = 16'd2;
      c.enable_pulse_len = 8'd1;
      program_regs(c);
      byte_then_ticks(REQ_CMD, 8'h00);
      byte_then_ticks(REQ_CMD, 8'h03);
      byte_then_ticks(REQ_CMD, 8'h04);
      byte_then_ticks(REQ_DATA, 8'hFF);
      offer(REQ_DATA, 8'h00);
      offer(REQ_CMD, 8'h5A);
      repeat (byte_ticks(REQ_DATA, 8'h00)) offer(REQ_TICK, 8'h00);
      offer(REQ_SPARE, 8'hFF);
      byte_then_ticks(REQ_CMD, 8'hFF);

      drain();
      c.powerup_wait      = 16'($urandom);
      c.second_init_wait  = 16'($urandom);
      c.third_init_wait   = 16'($urandom);
      c.short_settle_wait = 16'($urandom_range(1, 6));
      c.long_settle_wait  = 16'($urandom_range(2, 12));
      c.enable_pulse_len  = 8'($urandom_range(1, 3));
      program_regs(c);
      for (int i = 0; i < 18; i++) begin
         if (i == 8)
            hold_request = 1'b1;
         random_sequence();
      end
      quiesce();

      drain();
      c.powerup_wait      = 16'hFFFF;
      c.second_init_wait  = 16'h0000;
      c.third_init_wait   = 16'hFFFF;
      c.short_settle_wait = 16'h0000;
      c.long_settle_wait  = 16'h0000;
      c.enable_pulse_len  = 8'd12;
      program_regs(c);
      random_sequence();
      random_sequence();
      quiesce();

      drain();
      c.powerup_wait      = 16'h0000;
      c.second_init_wait  = 16'($urandom);
      c.third_init_wait   = 16'h0000;
      c.short_settle_wait = 16'($urandom_range(0, 3));
      c.long_settle_wait  = 16'($urandom_range(0, 3));
      c.enable_pulse_len  = 8'($urandom_range(1, 2));
      program_regs(c);
      for (int i = 0; i < 12; i++)
         random_sequence();
      quiesce();

      // counter extremes, zero pulse length
      drain();
      c.short_settle_wait = 16'hFFFF;
      c.long_settle_wait  = 16'hFFFF;
      c.enable_pulse_len  = 8'h00;
      program_regs(c);
      offer(REQ_CMD, 8'h01);
      repeat (20) offer(tick_code(), 8'($urandom));
      offer(REQ_DATA, 8'($urandom));
      repeat (5) offer(REQ_TICK, 8'($urandom));

      drain();
      repeat (20) @(posedge clock);
      $display("Run covered %0d requests (%0d bytes offered) across %0d register settings,",
               items_sent, bytes_offered, settings_used);
      $display("with boot, busy drops, the spare request code, a long output stall and wait extremes.");
      if (fail_count == 0 && pending_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
